FILE: src/mbd_pkg.sv
package mbd_pkg;

    // Block format.
    localparam int unsigned WIN_LEN          = 20;
    localparam int unsigned HEADER_LEN       = 64;
    localparam int unsigned SIZE_OFFSET      = 16;
    localparam int unsigned HARD_BLOCK_LIMIT = 8192;
    localparam int unsigned MAX_STREAM_BYTES = 268435456;

    localparam logic [7:0] MAGIC_0 = 8'h74;
    localparam logic [7:0] MAGIC_1 = 8'h7A;
    localparam logic [7:0] MAGIC_2 = 8'h66;
    localparam logic [7:0] MAGIC_3 = 8'h33;

    // Register widths and indexes.
    localparam int unsigned LEN_W   = 29;
    localparam int unsigned LIMIT_W = 14;
    localparam int unsigned INDEX_W = 13;
    localparam int unsigned SIZE_W  = 32;

    localparam logic REG_STREAM_LENGTH = 1'b0;
    localparam logic REG_BLOCK_LIMIT   = 1'b1;

    // Default depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Kinds of result commands.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data;
        logic [INDEX_W-1:0] index;
        logic               first;
        logic               last;
    } cmd_t;

endpackage

FILE: src/mbd_queue.sv
module mbd_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/mbd_front.sv
module mbd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [mbd_pkg::LEN_W-1:0]  cfg_data,
    input  logic                       push,
    input  logic [7:0]                 data_byte,
    output logic                       full,
    output logic                       q_push,
    output mbd_pkg::cmd_t              q_data,
    input  logic                       q_full
);

    import mbd_pkg::*;

    localparam logic [1:0] MODE_SEARCH  = 2'd0;
    localparam logic [1:0] MODE_HEADER  = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;
    localparam logic [1:0] MODE_DONE    = 2'd3;

    localparam int unsigned FILL_W = $clog2(WIN_LEN + 1);
    localparam int unsigned SKIP_W = $clog2(HEADER_LEN);

    logic [LEN_W-1:0]   stream_length_reg;
    logic [LIMIT_W-1:0] block_limit_reg;

    logic [7:0]         win_reg [WIN_LEN];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [LEN_W-1:0]   pos_reg;
    logic [LEN_W-1:0]   pos_next;
    logic [LEN_W:0]     pos45_reg;
    logic [LEN_W:0]     pos45_next;
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic [SKIP_W-1:0]  skip_reg;
    logic [SKIP_W-1:0]  skip_next;
    logic [SKIP_W-1:0]  skip_dec;
    logic [SIZE_W-1:0]  remain_reg;
    logic [SIZE_W-1:0]  remain_next;
    logic [SIZE_W-1:0]  remain_dec;
    logic [LIMIT_W-1:0] found_reg;
    logic [LIMIT_W-1:0] found_next;
    logic               first_reg;
    logic               first_next;

    logic [LEN_W-1:0]   len_eff;
    logic [LIMIT_W-1:0] limit_eff;
    logic               accept;
    logic               active;
    logic               win_shift;
    logic               window_full;
    logic               magic_hit;
    logic [SIZE_W-1:0]  size_word;
    logic               fits;
    logic               candidate;
    logic [INDEX_W-1:0] cur_index;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign len_eff   = (stream_length_reg > LEN_W'(MAX_STREAM_BYTES)) ?
                       LEN_W'(MAX_STREAM_BYTES) : stream_length_reg;
    assign limit_eff = (block_limit_reg > LIMIT_W'(HARD_BLOCK_LIMIT)) ?
                       LIMIT_W'(HARD_BLOCK_LIMIT) : block_limit_reg;

    // Bytes past the end of the stream and bytes after an error are taken and dropped.
    assign active    = accept && (mode_reg != MODE_DONE) && (pos_reg < len_eff);
    assign win_shift = active && (mode_reg == MODE_SEARCH);

    // The candidate sits at window slot 0 once this byte is shifted in.
    assign window_full = (fill_reg >= FILL_W'(WIN_LEN - 1));
    assign magic_hit   = (win_reg[1] == MAGIC_0) && (win_reg[2] == MAGIC_1) &&
                         (win_reg[3] == MAGIC_2) && (win_reg[4] == MAGIC_3);
    assign size_word   = {data_byte, win_reg[SIZE_OFFSET + 3], win_reg[SIZE_OFFSET + 2],
                          win_reg[SIZE_OFFSET + 1]};

    // Candidate start i = pos - 19, so i + 64 = pos + 45. Header and payload fit
    // exactly when size + pos + 45 <= length.
    assign fits      = ({1'b0, size_word} + (SIZE_W + 1)'(pos45_reg)) <=
                       (SIZE_W + 1)'(len_eff);
    assign candidate = window_full && magic_hit && fits;

    assign cur_index  = INDEX_W'(found_reg - 1'b1);
    assign skip_dec   = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    always_comb
    begin
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        pos45_next  = pos45_reg;
        mode_next   = mode_reg;
        skip_next   = skip_reg;
        remain_next = remain_reg;
        found_next  = found_reg;
        first_next  = first_reg;
        q_push      = 1'b0;
        q_data      = '0;
        if (active)
        begin
            pos_next   = pos_reg + 1'b1;
            pos45_next = pos45_reg + 1'b1;
            unique case (mode_reg)
                MODE_SEARCH:
                begin
                    fill_next = window_full ? FILL_W'(WIN_LEN) : fill_reg + 1'b1;
                    if (candidate)
                    begin
                        if (found_reg >= limit_eff)
                        begin
                            mode_next   = MODE_DONE;
                            q_push      = 1'b1;
                            q_data.kind = KIND_ERROR;
                        end
                        else
                        begin
                            found_next  = found_reg + 1'b1;
                            remain_next = size_word;
                            skip_next   = SKIP_W'(HEADER_LEN - WIN_LEN);
                            mode_next   = MODE_HEADER;
                            fill_next   = '0;
                        end
                    end
                end
                MODE_HEADER:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        if (remain_reg == '0)
                        begin
                            mode_next    = MODE_SEARCH;
                            q_push       = 1'b1;
                            q_data.kind  = KIND_EMPTY;
                            q_data.index = cur_index;
                        end
                        else
                        begin
                            mode_next  = MODE_PAYLOAD;
                            first_next = 1'b1;
                        end
                    end
                end
                MODE_PAYLOAD:
                begin
                    first_next   = 1'b0;
                    remain_next  = remain_dec;
                    q_push       = 1'b1;
                    q_data.kind  = KIND_DATA;
                    q_data.data  = data_byte;
                    q_data.index = cur_index;
                    q_data.first = first_reg;
                    q_data.last  = (remain_dec == '0);
                    if (remain_dec == '0)
                    begin
                        mode_next = MODE_SEARCH;
                    end
                end
                MODE_DONE:
                begin
                    mode_next = MODE_DONE;
                end
                default:
                begin
                    mode_next = MODE_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= '0;
            block_limit_reg   <= LIMIT_W'(HARD_BLOCK_LIMIT);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_STREAM_LENGTH)
            begin
                stream_length_reg <= cfg_data;
            end
            else if (cfg_index == REG_BLOCK_LIMIT)
            begin
                block_limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            pos_reg    <= '0;
            pos45_reg  <= (LEN_W + 1)'(HEADER_LEN - WIN_LEN + 1);
            mode_reg   <= MODE_SEARCH;
            skip_reg   <= '0;
            remain_reg <= '0;
            found_reg  <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            pos45_reg  <= pos45_next;
            mode_reg   <= mode_next;
            skip_reg   <= skip_next;
            remain_reg <= remain_next;
            found_reg  <= found_next;
            first_reg  <= first_next;
        end
    end

    // Window contents count only up to the fill level, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (win_shift)
        begin
            for (int k = 0; k < WIN_LEN - 1; k++)
            begin
                win_reg[k] <= win_reg[k + 1];
            end
            win_reg[WIN_LEN - 1] <= data_byte;
        end
    end

endmodule

FILE: src/mbd_back.sv
module mbd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  mbd_pkg::cmd_t                q_data,
    output logic                         q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [7:0]                   payload_byte,
    output logic [mbd_pkg::INDEX_W-1:0]  block_index,
    output logic                         block_first,
    output logic                         block_last,
    output logic                         empty_block,
    output logic                         limit_error,
    output logic                         run_last
);

    import mbd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic               load;
    logic [7:0]         byte_next;
    logic [INDEX_W-1:0] index_next;
    logic               first_next;
    logic               last_next;
    logic               empty_next;
    logic               error_next;

    // The output register refills whenever it is free or being drained.
    assign load     = !q_empty && (!valid_reg || pop);
    assign q_pop    = load;
    assign empty    = !valid_reg;
    assign run_last = 1'b1;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        byte_next  = '0;
        index_next = '0;
        first_next = 1'b0;
        last_next  = 1'b0;
        empty_next = 1'b0;
        error_next = 1'b0;
        unique case (q_data.kind)
            KIND_DATA:
            begin
                byte_next  = q_data.data;
                index_next = q_data.index;
                first_next = q_data.first;
                last_next  = q_data.last;
            end
            KIND_EMPTY:
            begin
                index_next = q_data.index;
                first_next = 1'b1;
                last_next  = 1'b1;
                empty_next = 1'b1;
            end
            KIND_ERROR:
            begin
                error_next = 1'b1;
            end
            default:
            begin
                error_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            payload_byte <= byte_next;
            block_index  <= index_next;
            block_first  <= first_next;
            block_last   <= last_next;
            empty_block  <= empty_next;
            limit_error  <= error_next;
        end
    end

endmodule

FILE: src/magic_block_deframer.sv
// Block deframer for a decoded byte stream of known length.
// Input channel: a byte is transferred on a rising edge with push high and full low.
// Every transferred byte is consumed, including bytes past the stream end, which
// are dropped. Result channel: while empty is low the oldest result is on the
// ports; it is transferred on a rising edge with pop high.
// Configuration: cfg_write with cfg_index 0 sets stream_length, index 1 sets
// block_limit; write only while the block is idle.
// Throughput is one byte per cycle while full is low. The front end decides each
// candidate in the same cycle the twentieth window byte arrives, using one 33-bit
// add and compare. A result passes through the command queue and then the output
// register: the front end queues a command when its input byte is transferred,
// and the back end loads it there once the register is free or being drained.
// When the receiver stalls, commands collect in the queue (QUEUE_DEPTH entries plus
// the output register); full rises once the queue is full and falls as soon as
// the back end takes a command.
// Reset clears the scan state, queue and output register, sets stream_length to 0
// and block_limit to 8192. After a limit error, all further bytes are dropped
// until the next reset.
module magic_block_deframer #(
    parameter int unsigned QUEUE_DEPTH = mbd_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [mbd_pkg::LEN_W-1:0]    cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   data_byte,
    input  logic                         pop,
    output logic                         empty,
    output logic [7:0]                   payload_byte,
    output logic [mbd_pkg::INDEX_W-1:0]  block_index,
    output logic                         block_first,
    output logic                         block_last,
    output logic                         empty_block,
    output logic                         limit_error,
    output logic                         run_last
);

    import mbd_pkg::*;

    localparam int unsigned CMD_W = $bits(cmd_t);

    logic             cq_push;
    logic             cq_full;
    logic             cq_pop;
    logic             cq_empty;
    cmd_t             cq_in;
    cmd_t             cq_out;
    logic [CMD_W-1:0] cq_out_bits;

    // The front end scans the stream and emits one command per result.
    mbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .data_byte (data_byte),
        .full      (full),
        .q_push    (cq_push),
        .q_data    (cq_in),
        .q_full    (cq_full)
    );

    // The queue decouples the scanner from the result side.
    mbd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cq_push),
        .push_data (cq_in),
        .full      (cq_full),
        .pop       (cq_pop),
        .pop_data  (cq_out_bits),
        .empty     (cq_empty)
    );

    assign cq_out = cmd_t'(cq_out_bits);

    // The back end turns commands into result fields and holds the output register.
    mbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (cq_empty),
        .q_data       (cq_out),
        .q_pop        (cq_pop),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .block_index  (block_index),
        .block_first  (block_first),
        .block_last   (block_last),
        .empty_block  (empty_block),
        .limit_error  (limit_error),
        .run_last     (run_last)
    );

endmodule

FILE: tb/sv/magic_block_deframer_checker.sv
`timescale 1ns / 1ps

module magic_block_deframer_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [mbd_pkg::LEN_W-1:0]    cfg_data,
    input  logic                         push,
    input  logic                         full,
    input  logic [7:0]                   data_byte,
    input  logic                         pop,
    input  logic                         empty,
    input  logic [7:0]                   payload_byte,
    input  logic [mbd_pkg::INDEX_W-1:0]  block_index,
    input  logic                         block_first,
    input  logic                         block_last,
    input  logic                         empty_block,
    input  logic                         limit_error,
    input  logic                         run_last,
    output int                           failures,
    output int                           pending
);
    import mbd_pkg::*;

    localparam int MAX_REPORTED = 200;

    typedef enum logic [1:0] {
        SEEK,
        SKIP_HEADER,
        PASS_PAYLOAD,
        HALTED
    } scan_state_e;

    typedef struct packed {
        logic [7:0]         data;
        logic [INDEX_W-1:0] index;
        logic               start_mark;
        logic               end_mark;
        logic               empty_flag;
        logic               error_flag;
        logic               tail;
    } deframe_result_t;

    logic [LEN_W-1:0]   length_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [7:0]         window [WIN_LEN];
    int unsigned        window_fill;
    logic [LEN_W-1:0]   position;
    scan_state_e        scan_state;
    logic [5:0]         header_left;
    logic [SIZE_W-1:0]  payload_left;
    logic [LIMIT_W-1:0] blocks_found;
    logic               first_pending;

    deframe_result_t    expected_results [$];

    task automatic report_mismatch(input string msg);
        if (failures < MAX_REPORTED)
            $display("mismatch at %0t ns: %s", $time, msg);
        failures++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic reset_model();
        length_reg    = '0;
        limit_reg     = LIMIT_W'(HARD_BLOCK_LIMIT);
        for (int k = 0; k < WIN_LEN; k++)
            window[k] = 8'h00;
        window_fill   = 0;
        position      = '0;
        scan_state    = SEEK;
        header_left   = '0;
        payload_left  = '0;
        blocks_found  = '0;
        first_pending = 1'b0;
        expected_results.delete();
        failures      = 0;
    endtask

    // Works out the results that one transferred byte causes and queues them.
    task automatic advance_scan(input logic [7:0] value);
        longint unsigned span;
        longint unsigned lim;
        longint unsigned cand;
        longint unsigned size;
        deframe_result_t res;

        span = (length_reg > MAX_STREAM_BYTES) ? MAX_STREAM_BYTES : length_reg;
        lim  = (limit_reg > HARD_BLOCK_LIMIT) ? HARD_BLOCK_LIMIT : limit_reg;
        res      = '0;
        res.tail = 1'b1;

        // Bytes past the stream end and bytes after a limit error are dropped.
        if (scan_state == HALTED || position >= span)
            return;
        cand     = position;
        position = position + 1'b1;

        case (scan_state)
            SEEK: begin
                for (int k = 0; k < WIN_LEN - 1; k++)
                    window[k] = window[k + 1];
                window[WIN_LEN - 1] = value;
                if (window_fill < WIN_LEN)
                    window_fill++;
                if (window_fill == WIN_LEN) begin
                    cand = cand - (WIN_LEN - 1);
                    size = {window[SIZE_OFFSET + 3], window[SIZE_OFFSET + 2],
                            window[SIZE_OFFSET + 1], window[SIZE_OFFSET]};
                    if (window[0] == MAGIC_0 && window[1] == MAGIC_1 &&
                        window[2] == MAGIC_2 && window[3] == MAGIC_3 &&
                        cand + HEADER_LEN <= span &&
                        size <= span - (cand + HEADER_LEN)) begin
                        if (blocks_found >= lim) begin
                            scan_state     = HALTED;
                            res.error_flag = 1'b1;
                            expected_results.push_back(res);
                        end
                        else begin
                            blocks_found++;
                            payload_left = size;
                            header_left  = HEADER_LEN - WIN_LEN;
                            scan_state   = SKIP_HEADER;
                            window_fill  = 0;
                        end
                    end
                end
            end
            SKIP_HEADER: begin
                if (header_left > 0)
                    header_left--;
                if (header_left == 0) begin
                    if (payload_left == 0) begin
                        scan_state     = SEEK;
                        res.index      = blocks_found - 1'b1;
                        res.start_mark = 1'b1;
                        res.end_mark   = 1'b1;
                        res.empty_flag = 1'b1;
                        expected_results.push_back(res);
                    end
                    else begin
                        scan_state    = PASS_PAYLOAD;
                        first_pending = 1'b1;
                    end
                end
            end
            default: begin
                res.data       = value;
                res.index      = blocks_found - 1'b1;
                res.start_mark = first_pending;
                first_pending  = 1'b0;
                if (payload_left > 0)
                    payload_left--;
                res.end_mark = (payload_left == 0);
                if (res.end_mark)
                    scan_state = SEEK;
                expected_results.push_back(res);
            end
        endcase
    endtask

    task automatic check_result();
        deframe_result_t want;

        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: byte %0h index %0d error %0b",
                                      payload_byte, block_index, limit_error));
            return;
        end
        want = expected_results.pop_front();
        compare_field("payload_byte", payload_byte, want.data);
        compare_field("block_index", block_index, want.index);
        compare_field("block_first", block_first, want.start_mark);
        compare_field("block_last", block_last, want.end_mark);
        compare_field("empty_block", empty_block, want.empty_flag);
        compare_field("limit_error", limit_error, want.error_flag);
        compare_field("run_last", run_last, want.tail);
    endtask

    // Inputs change on the falling edge, so everything here sees settled values.
    always @(posedge clk) begin
        if (!rst_n)
            reset_model();
        else begin
            if (pop && !empty)
                check_result();
            if (cfg_write) begin
                if (cfg_index == REG_STREAM_LENGTH)
                    length_reg = cfg_data;
                else
                    limit_reg = cfg_data[LIMIT_W-1:0];
            end
            if (push && !full)
                advance_scan(data_byte);
        end
        pending = expected_results.size();
    end

endmodule

FILE: tb/sv/magic_block_deframer_test.sv
`timescale 1ns / 1ps

module magic_block_deframer_test;
    import mbd_pkg::*;

    // The four magic bytes, lowest byte first, so byte j is MAGIC_WORD[8*j +: 8].
    localparam logic [31:0] MAGIC_WORD    = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};
    localparam int          RANDOM_FRAMES = 6;
    // Cycles the receiver holds off in the pressure test; far longer than it takes
    // to fill the command queue and the output register.
    localparam int          LONG_HOLD     = 150;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic                cfg_index;
    logic [LEN_W-1:0]    cfg_data;
    logic                push;
    logic                full;
    logic [7:0]          data_byte;
    logic                pop;
    logic                empty;
    logic [7:0]          payload_byte;
    logic [INDEX_W-1:0]  block_index;
    logic                block_first;
    logic                block_last;
    logic                empty_block;
    logic                limit_error;
    logic                run_last;

    int                  mismatch_count;
    int                  results_outstanding;

    // The stimulus keeps its own count of the stream position so that it can place
    // the stream end right at the edges of a header or a payload.
    longint unsigned     stream_pos;
    longint unsigned     stream_span;

    // Burst flags switch off the random gaps on one side. Each step of
    // long_hold_req asks the receiver for one long stall.
    logic                sender_burst;
    logic                receiver_burst;
    int                  long_hold_req;

    magic_block_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .block_index  (block_index),
        .block_first  (block_first),
        .block_last   (block_last),
        .empty_block  (empty_block),
        .limit_error  (limit_error),
        .run_last     (run_last)
    );

    magic_block_deframer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .block_index  (block_index),
        .block_first  (block_first),
        .block_last   (block_last),
        .empty_block  (empty_block),
        .limit_error  (limit_error),
        .run_last     (run_last),
        .failures     (mismatch_count),
        .pending      (results_outstanding)
    );

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hard stop in case the block hangs on either channel.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Sends one byte: an optional random gap with push low, then push high until
    // the byte is transferred. When the gap is zero, push simply stays high, so
    // back-to-back bytes go out on consecutive cycles while full stays low.
    task automatic send_byte(input logic [7:0] value);
        int gap;

        gap = sender_burst ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // The block only counts bytes that fall inside the stream.
        if (stream_pos < stream_span)
            stream_pos++;
    endtask

    task automatic send_noise(input int unsigned count);
        repeat (count)
            send_byte($urandom_range(0, 255));
    endtask

    // Sends the first twenty bytes of a candidate: magic, filler and the
    // little-endian payload size. That is all the block needs to decide on it.
    task automatic send_window(input logic [31:0] size);
        for (int j = 0; j < 4; j++)
            send_byte(MAGIC_WORD[8*j +: 8]);
        send_noise(SIZE_OFFSET - 4);
        for (int j = 0; j < 4; j++)
            send_byte(size[8*j +: 8]);
    endtask

    // A whole block: window, the rest of the header and a random payload.
    task automatic send_frame(input int unsigned size);
        send_window(size);
        send_noise(HEADER_LEN - WIN_LEN);
        send_noise(size);
    endtask

    // The sender pauses until every expected result has been transferred, then
    // stays idle with push low before going on, since a byte that causes no result
    // may still be in flight when the last result comes out.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (results_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_reg(input logic idx, input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_STREAM_LENGTH)
            stream_span = (value > MAX_STREAM_BYTES) ? MAX_STREAM_BYTES : value;
    endtask

    // Result side: for every result draw a hold-off, then keep pop high until a
    // transfer happens. A new long-hold request turns the next hold-off into
    // one long stall, counted here.
    initial begin
        int hold;
        int holds_taken;

        pop         = 1'b0;
        holds_taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            hold = receiver_burst ? 0 : $urandom_range(0, 4);
            if (long_hold_req != holds_taken) begin
                hold = LONG_HOLD;
                holds_taken++;
            end
            if (hold > 0) begin
                pop <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    initial begin
        int kind;
        int depth;
        int waited;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_STREAM_LENGTH;
        cfg_data       = '0;
        push           = 1'b0;
        data_byte      = 8'h00;
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
        long_hold_req  = 0;
        stream_pos     = 0;
        stream_span    = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With a stream length of zero every byte lies past the end and is dropped.
        write_reg(REG_STREAM_LENGTH, '0);
        write_reg(REG_BLOCK_LIMIT, '1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(MAGIC_0);
        settle();

        // The largest register value; the block clamps it to the largest stream.
        write_reg(REG_STREAM_LENGTH, '1);

        // Empty block, then blocks of one and five bytes. The last two start right
        // after the previous payload, so the window begins empty for them.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0);
        send_frame(1);
        send_frame(5);

        // Near misses: a magic broken at its last byte, one broken at its third
        // byte, and a full candidate whose payload can never fit.
        send_byte(MAGIC_0);
        send_byte(MAGIC_1);
        send_byte(MAGIC_2);
        send_byte(8'h00);
        send_byte(MAGIC_0);
        send_byte(MAGIC_1);
        send_byte(MAGIC_3);
        send_window(32'hFFFF_FFFF);
        send_noise(3);

        // Pressure: the receiver stalls for a long stretch while the sender pushes
        // a long payload back to back, so the queue fills and full has to rise.
        sender_burst = 1'b1;
        long_hold_req++;
        send_frame(60);
        sender_burst = 1'b0;
        settle();

        // Header does not fit: the stream ends one byte short of the header end.
        write_reg(REG_STREAM_LENGTH, LEN_W'(stream_pos + HEADER_LEN - 1));
        send_window(32'd0);
        settle();

        // Payload one byte too long for what is left of the stream.
        write_reg(REG_STREAM_LENGTH, LEN_W'(stream_pos + HEADER_LEN + 3));
        send_window(32'd4);
        settle();

        // Payload ends exactly at the stream end; the bytes after it are dropped.
        write_reg(REG_STREAM_LENGTH, LEN_W'(stream_pos + HEADER_LEN + 3));
        send_frame(3);
        send_noise(2);
        settle();

        // Reopen the stream at exactly the largest length and the hard block limit.
        write_reg(REG_STREAM_LENGTH, LEN_W'(MAX_STREAM_BYTES));
        write_reg(REG_BLOCK_LIMIT, LEN_W'(HARD_BLOCK_LIMIT));

        // Random part: mostly well-formed blocks with random content and random
        // noise between them, with some broken magics and oversized candidates.
        for (int k = 0; k < RANDOM_FRAMES; k++) begin
            if (k == RANDOM_FRAMES / 2) begin
                settle();
                write_reg(REG_STREAM_LENGTH, LEN_W'(MAX_STREAM_BYTES - 1));
                write_reg(REG_BLOCK_LIMIT, LEN_W'(1000));
            end
            sender_burst   = ($urandom_range(0, 3) == 0);
            receiver_burst = ($urandom_range(0, 3) == 0);
            send_noise($urandom_range(0, 5));
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                depth = $urandom_range(1, 3);
                for (int j = 0; j < depth; j++)
                    send_byte(MAGIC_WORD[8*j +: 8]);
                send_byte(8'h00);
            end
            else if (kind == 1)
                send_window($urandom | 32'h1000_0000);
            else if ($urandom_range(0, 7) == 0)
                send_frame($urandom_range(13, 48));
            else
                send_frame($urandom_range(0, 12));
        end
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
        settle();

        // Limit error: blocks were already accepted, so with a limit of one the next
        // accepted candidate raises the error, and everything after it is dropped.
        write_reg(REG_BLOCK_LIMIT, LEN_W'(1));
        send_noise(2);
        send_frame(2);
        send_frame(0);

        // Wait for the remaining results, with a bound, then keep watching with push low
        // to catch any result that should not be there.
        @(negedge clk);
        push <= 1'b0;
        waited = 0;
        while (results_outstanding != 0 && waited < 2000) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);

        if (mismatch_count == 0 && results_outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
